// ===== rtl/owspi_pkg.sv =====
// Shared constants and types for the 1-Wire-over-SPI slot master.
package owspi_pkg;

    // Slot counts of the reset/presence sequence and of byte reads and writes
    localparam logic [3:0] LOW_BYTES    = 4'd8;
    localparam logic [3:0] SAMPLE_BYTES = 4'd4;
    localparam logic [3:0] DATA_SLOTS   = 4'd8;

    // Item kinds carried on s_tuser
    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_REPLY = 2'd3;

    // Operation phase codes
    localparam logic [1:0] OP_RESET_LOW    = 2'd0;
    localparam logic [1:0] OP_READ         = 2'd1;
    localparam logic [1:0] OP_WRITE        = 2'd2;
    localparam logic [1:0] OP_RESET_SAMPLE = 2'd3;

    // SPI bytes that shape the bus slots
    localparam logic [7:0] SLOT_LOW  = 8'h00;
    localparam logic [7:0] SLOT_ONE  = 8'h7F;
    localparam logic [7:0] SLOT_HIGH = 8'hFF;
    localparam logic [5:0] READ_ONES = 6'h3F;

    localparam int RESULT_BITS = 19;
    localparam int TDATA_OUT_W = 24;

    typedef struct packed {
        logic       busy_res;
        logic [7:0] result_byte;
        logic       done_res;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } result_t;

endpackage

// ===== rtl/owspi_core.sv =====
// Operation sequencer: state registers and next-result logic per transfer.
module owspi_core
    import owspi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [1:0]  mode,
    input  logic [7:0]  value,
    output result_t     result
);

    logic [1:0] operation_reg, operation_next;
    logic [3:0] slot_count_reg, slot_count_next;
    logic [7:0] shift_data_reg, shift_data_next;
    logic       active_reg, active_next;
    logic [7:0] shifted;

    assign shifted = {1'b0, shift_data_reg[7:1]};

    always_comb begin
        operation_next  = operation_reg;
        slot_count_next = slot_count_reg;
        shift_data_next = shift_data_reg;
        active_next     = active_reg;
        result          = '0;
        unique case (mode)
            MODE_RESET: begin
                operation_next  = OP_RESET_LOW;
                slot_count_next = 4'd1;
                shift_data_next = '0;
                active_next     = 1'b1;
                result.tx_valid = 1'b1;
                result.tx_byte  = SLOT_LOW;
            end
            MODE_READ: begin
                operation_next  = OP_READ;
                slot_count_next = 4'd1;
                shift_data_next = '0;
                active_next     = 1'b1;
                result.tx_valid = 1'b1;
                result.tx_byte  = SLOT_ONE;
            end
            MODE_WRITE: begin
                operation_next  = OP_WRITE;
                slot_count_next = 4'd1;
                shift_data_next = value;
                active_next     = 1'b1;
                result.tx_valid = 1'b1;
                result.tx_byte  = value[0] ? SLOT_ONE : SLOT_LOW;
            end
            default: begin
                if (active_reg) begin
                    unique case (operation_reg)
                        OP_RESET_LOW: begin
                            result.tx_valid = 1'b1;
                            if (slot_count_reg < LOW_BYTES) begin
                                result.tx_byte  = SLOT_LOW;
                                slot_count_next = slot_count_reg + 4'd1;
                            end else begin
                                result.tx_byte  = SLOT_HIGH;
                                operation_next  = OP_RESET_SAMPLE;
                                slot_count_next = 4'd1;
                                shift_data_next = '0;
                            end
                        end
                        OP_RESET_SAMPLE: begin
                            // a pulled-low reply counts as one presence sample
                            shift_data_next = shift_data_reg + {7'd0, (value == 8'h00)};
                            if (slot_count_reg >= SAMPLE_BYTES) begin
                                result.done_res    = 1'b1;
                                result.result_byte = shift_data_next;
                                active_next        = 1'b0;
                            end else begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = SLOT_HIGH;
                                slot_count_next = slot_count_reg + 4'd1;
                            end
                        end
                        OP_READ: begin
                            shift_data_next = {(value[5:0] == READ_ONES), shift_data_reg[7:1]};
                            if (slot_count_reg >= DATA_SLOTS) begin
                                result.done_res    = 1'b1;
                                result.result_byte = shift_data_next;
                                active_next        = 1'b0;
                            end else begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = SLOT_ONE;
                                slot_count_next = slot_count_reg + 4'd1;
                            end
                        end
                        OP_WRITE: begin
                            shift_data_next = shifted;
                            if (slot_count_reg >= DATA_SLOTS) begin
                                result.done_res = 1'b1;
                                active_next     = 1'b0;
                            end else begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = shifted[0] ? SLOT_ONE : SLOT_LOW;
                                slot_count_next = slot_count_reg + 4'd1;
                            end
                        end
                        default: begin
                            operation_next = operation_reg;
                        end
                    endcase
                end
            end
        endcase
        result.busy_res = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operation_reg  <= OP_RESET_LOW;
            slot_count_reg <= '0;
            shift_data_reg <= '0;
            active_reg     <= 1'b0;
        end else if (accept) begin
            operation_reg  <= operation_next;
            slot_count_reg <= slot_count_next;
            shift_data_reg <= shift_data_next;
            active_reg     <= active_next;
        end
    end

endmodule

// ===== rtl/onewire_over_spi_slot_master_unit.sv =====
// Top level: 1-Wire master that turns SPI byte replies into the next bus slot.
//
// Input channel (s_): s_tuser selects the item kind: start reset/presence,
// start byte read, start byte write, or an SPI byte returned by the link.
// s_tdata carries the byte to write or the byte received.
// Result channel (m_): exactly one result per input transfer, carrying the
// next SPI byte to send (with its valid flag), the done flag, the read byte
// or presence count, and the busy flag.
// Each result is registered in the output stage described below.
// Throughput: one transfer per cycle while s_tready is high, set by the
// combinational sequencer update between input handshake and output stage.
// A two-entry output stage (output register plus skid register) lets the
// block take a new transfer while a result waits; s_tready drops only when
// both entries are full because the receiver stalled.
// Reset (aresetn low, synchronous) makes the sequencer idle and empties the
// output stage. A reply arriving while idle yields an all-zero result; a
// start while busy abandons the running operation.
module onewire_over_spi_slot_master_unit
    import owspi_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] value
    input  logic [1:0]             s_tuser,   // [1:0] mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] done_res, [17:10] result_byte,
    // [18] busy_res, [23:19] zero
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    result_t new_result;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;
    logic    out_take;

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign out_take = out_valid_reg & m_tready;

    owspi_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .mode    (s_tuser),
        .value   (s_tdata),
        .result  (new_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || out_take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || out_take) begin
                out_data_reg <= new_result;
            end else begin
                skid_data_reg <= new_result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W - RESULT_BITS){1'b0}}, out_data_reg};

    // skid entry only fills behind a held output entry
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // no SPI byte value without a send request
    a_tx_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'h00))
        else $error("tx_byte nonzero while tx_valid low");

    // a completed operation is no longer busy and sends nothing more
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> (!m_tdata[18] && !m_tdata[0]))
        else $error("done result still busy or sending");

    // a full output stage followed by a take frees the input side
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> s_tready)
        else $error("skid entry did not drain after output transfer");

endmodule

// ===== dv/tb_onewire_over_spi_slot_master_unit.sv =====
// Testbench for the 1-Wire-over-SPI slot master: stream driver, monitor and slot predictor.
module tb_onewire_over_spi_slot_master_unit;
    import owspi_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int ITEM_TARGET = 1850;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] value;
    } slot_item_t;

    typedef enum {RX_OPEN, RX_COIN, RX_ONE_IN_FOUR, RX_RARE_STALL} rx_pattern_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [7:0]             s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [TDATA_OUT_W-1:0] m_tdata;

    onewire_over_spi_slot_master_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    slot_item_t item_q[$];
    result_t    slot_q[$];

    // predictor state
    logic [1:0] op_phase   = OP_RESET_LOW;
    logic [3:0] slot_cnt   = '0;
    logic [7:0] shift_reg  = '0;
    logic       seq_active = 1'b0;

    bit in_fire      = 1'b0;
    bit sender_gappy = 1'b1;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;
    int n_errors     = 0;
    int n_queued     = 0;
    int n_in         = 0;
    int n_out        = 0;
    int n_in_stalls  = 0;
    int n_presence   = 0;
    int n_reads      = 0;
    int n_writes     = 0;
    int n_aborts     = 0;
    int n_idle_reply = 0;

    function automatic logic [7:0] write_slot_byte(input logic bit_val);
        return bit_val ? SLOT_ONE : SLOT_LOW;
    endfunction

    // Advances the predicted sequencer by one transfer and returns the expected result.
    function automatic result_t next_slot(input logic [1:0] mode, input logic [7:0] value);
        result_t r;
        r = '0;
        if (mode != MODE_REPLY && seq_active)
            n_aborts++;
        case (mode)
            MODE_RESET: begin
                op_phase = OP_RESET_LOW;
                slot_cnt = 4'd1;
                shift_reg = '0;
                seq_active = 1'b1;
                r.tx_valid = 1'b1;
                r.tx_byte = SLOT_LOW;
            end
            MODE_READ: begin
                op_phase = OP_READ;
                slot_cnt = 4'd1;
                shift_reg = '0;
                seq_active = 1'b1;
                r.tx_valid = 1'b1;
                r.tx_byte = SLOT_ONE;
            end
            MODE_WRITE: begin
                op_phase = OP_WRITE;
                slot_cnt = 4'd1;
                shift_reg = value;
                seq_active = 1'b1;
                r.tx_valid = 1'b1;
                r.tx_byte = write_slot_byte(value[0]);
            end
            default: begin
                if (!seq_active) begin
                    n_idle_reply++;
                end else begin
                    case (op_phase)
                        OP_RESET_LOW: begin
                            r.tx_valid = 1'b1;
                            if (slot_cnt < LOW_BYTES) begin
                                r.tx_byte = SLOT_LOW;
                                slot_cnt = slot_cnt + 4'd1;
                            end else begin
                                r.tx_byte = SLOT_HIGH;
                                op_phase = OP_RESET_SAMPLE;
                                slot_cnt = 4'd1;
                                shift_reg = '0;
                            end
                        end
                        OP_RESET_SAMPLE: begin
                            if (value == SLOT_LOW)
                                shift_reg = shift_reg + 8'd1;
                            if (slot_cnt >= SAMPLE_BYTES) begin
                                r.done_res = 1'b1;
                                r.result_byte = shift_reg;
                                seq_active = 1'b0;
                                n_presence++;
                            end else begin
                                r.tx_valid = 1'b1;
                                r.tx_byte = SLOT_HIGH;
                                slot_cnt = slot_cnt + 4'd1;
                            end
                        end
                        OP_READ: begin
                            shift_reg = shift_reg >> 1;
                            if (value[5:0] == READ_ONES)
                                shift_reg[7] = 1'b1;
                            if (slot_cnt >= DATA_SLOTS) begin
                                r.done_res = 1'b1;
                                r.result_byte = shift_reg;
                                seq_active = 1'b0;
                                n_reads++;
                            end else begin
                                r.tx_valid = 1'b1;
                                r.tx_byte = SLOT_ONE;
                                slot_cnt = slot_cnt + 4'd1;
                            end
                        end
                        default: begin
                            shift_reg = shift_reg >> 1;
                            if (slot_cnt >= DATA_SLOTS) begin
                                r.done_res = 1'b1;
                                seq_active = 1'b0;
                                n_writes++;
                            end else begin
                                r.tx_valid = 1'b1;
                                r.tx_byte = write_slot_byte(shift_reg[0]);
                                slot_cnt = slot_cnt + 4'd1;
                            end
                        end
                    endcase
                end
            end
        endcase
        r.busy_res = seq_active;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Monitor: predicts on every input transfer, checks every result transfer.
    always @(posedge aclk) begin : monitor
        result_t want;
        result_t got;
        in_fire = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && !s_tready)
                n_in_stalls++;
            if (in_fire) begin
                n_in++;
                slot_q.push_back(next_slot(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                n_out++;
                got = m_tdata[RESULT_BITS-1:0];
                if (slot_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                end else begin
                    want = slot_q.pop_front();
                    check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                    check_field("result_byte", want.result_byte, got.result_byte);
                    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    check_field("tdata pad", 8'h00, 8'(m_tdata[TDATA_OUT_W-1:RESULT_BITS]));
                end
            end
        end
    end

    // Driver: bursts of transfers with random gaps, holds an item until it is taken.
    always @(negedge aclk) begin : driver
        slot_item_t it;
        int unsigned burst_left;
        int unsigned gap_left;
        if (aresetn && !(s_tvalid && !in_fire)) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (item_q.size() != 0) begin
                it = item_q.pop_front();
                s_tuser  <= it.mode;
                s_tdata  <= it.value;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = (sender_gappy && $urandom_range(0, 2) != 0) ?
                               $urandom_range(1, 6) : 0;
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: runs randomly chosen stall patterns in turn; one long hold-off on request.
    always @(negedge aclk) begin : receiver
        rx_pattern_t pattern;
        int unsigned pattern_left;
        int unsigned hold_left;
        int unsigned tick;
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(30, 200);
            end else begin
                pattern_left--;
            end
            case (pattern)
                RX_OPEN:        m_tready <= 1'b1;
                RX_COIN:        m_tready <= 1'($urandom_range(0, 1));
                RX_ONE_IN_FOUR: m_tready <= (tick[1:0] == 2'd0);
                default:        m_tready <= ($urandom_range(0, 9) != 0);
            endcase
            tick++;
        end
    end

    // Watchdog: counts cycles without any transfer while work is outstanding.
    always @(posedge aclk) begin : watchdog
        int unsigned quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (item_q.size() == 0 && !s_tvalid && slot_q.size() == 0)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic [1:0] mode, input logic [7:0] value);
        slot_item_t it;
        it.mode = mode;
        it.value = value;
        item_q.push_back(it);
        n_queued++;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (item_q.size() != 0 || s_tvalid || slot_q.size() != 0);
    endtask

    // Op with random replies, maybe cut short or trailed by a stray reply, or one stray reply.
    task automatic queue_random_op();
        int unsigned pick;
        int unsigned replies;
        int unsigned i;
        logic [1:0] mode;
        logic [7:0] reply;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            queue_item(MODE_REPLY, 8'($urandom));
            return;
        end
        if (pick <= 5) begin
            mode = MODE_RESET;
            replies = 32'(LOW_BYTES) + 32'(SAMPLE_BYTES);
        end else if (pick <= 12) begin
            mode = MODE_READ;
            replies = 32'(DATA_SLOTS);
        end else begin
            mode = MODE_WRITE;
            replies = 32'(DATA_SLOTS);
        end
        queue_item(mode, 8'($urandom));
        if ($urandom_range(0, 9) == 0)
            replies = $urandom_range(0, replies - 1);
        for (i = 0; i < replies; i++) begin
            reply = 8'($urandom);
            if (mode == MODE_RESET && i >= LOW_BYTES && $urandom_range(0, 1) == 0)
                reply = SLOT_LOW;
            else if (mode == MODE_READ && $urandom_range(0, 1) == 0)
                reply = {2'($urandom), READ_ONES};
            queue_item(MODE_REPLY, reply);
        end
        if ($urandom_range(0, 14) == 0)
            queue_item(MODE_REPLY, 8'($urandom));
    endtask

    initial begin : stimulus
        int unsigned i;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: stray reply, full write, aborted read, full reset with four presence samples
        queue_item(MODE_REPLY, 8'hFF);
        queue_item(MODE_WRITE, 8'hA5);
        for (i = 0; i < DATA_SLOTS; i++)
            queue_item(MODE_REPLY, i[0] ? 8'hFF : 8'h00);
        queue_item(MODE_READ, 8'hFF);
        queue_item(MODE_REPLY, 8'h3F);
        queue_item(MODE_REPLY, 8'hC0);
        queue_item(MODE_RESET, 8'h5A);
        for (i = 0; i < LOW_BYTES; i++)
            queue_item(MODE_REPLY, i[0] ? 8'h00 : 8'hFF);
        for (i = 0; i < SAMPLE_BYTES; i++)
            queue_item(MODE_REPLY, SLOT_LOW);
        wait_drained();

        // long receiver hold-off with the sender streaming, so the input side backs up
        sender_gappy = 1'b0;
        hold_req = 1'b1;
        while (item_q.size() < 40)
            queue_random_op();
        wait_drained();
        sender_gappy = 1'b1;

        while (n_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0)
                sender_gappy = !sender_gappy;
            queue_random_op();
            while (item_q.size() > 32)
                @(posedge aclk);
        end
        wait_drained();
        repeat (4) @(posedge aclk);

        $display("Covered %0d transfers in, %0d results, %0d input stall cycles.",
                 n_in, n_out, n_in_stalls);
        $display("Completed %0d presence, %0d read, %0d write; %0d aborts, %0d idle replies.",
                 n_presence, n_reads, n_writes, n_aborts, n_idle_reply);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== onewire_over_spi_slot_master_unit.f =====
rtl/owspi_pkg.sv
rtl/owspi_core.sv
rtl/onewire_over_spi_slot_master_unit.sv
dv/tb_onewire_over_spi_slot_master_unit.sv
